/* rtl/gwmf_pkg.sv */
package gwmf_pkg;

	localparam int PIN_COUNT   = 8;
	localparam int SAMPLES_DEF = 8;
	localparam int THR_W       = 4;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 8;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 16;

	localparam logic [THR_W-1:0]     THR_RESET  = THR_W'(5);
	localparam logic [PIN_COUNT-1:0] MASK_RESET = '1;

	// Register indexes of the configuration channel.
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_PIN_ENABLE_MASK = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_READ    = 2'd1,
		OP_GET_PIN = 2'd2,
		OP_POLL    = 2'd3
	} opcode_t;

	// Packed so that ok lands in bit 0 of the output beat.
	typedef struct packed {
		logic                 ready_flag;
		logic                 pin_level;
		logic [PIN_COUNT-1:0] levels;
		logic                 ok;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

/* rtl/gwmf_core.sv */
module gwmf_core #(
	parameter int SAMPLES = gwmf_pkg::SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gwmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gwmf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                accept,
	input  gwmf_pkg::opcode_t                   opcode,
	input  logic [gwmf_pkg::PIN_COUNT-1:0]      sample_bits,
	input  logic [7:0]                          pin_index,
	output gwmf_pkg::result_t                   result
);
	import gwmf_pkg::*;

	localparam int CNT_W = $clog2(SAMPLES + 1);
	localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
	localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(SAMPLES - 1);

	logic [THR_W-1:0]     thr_q;
	logic [PIN_COUNT-1:0] mask_q;
	logic [CNT_W-1:0]     cnt_q [PIN_COUNT];
	logic [CNT_W-1:0]     cnt_inc [PIN_COUNT];
	logic [CNT_W-1:0]     pos_q;
	logic [PIN_COUNT-1:0] levels_q;
	logic                 ready_q;
	logic [PIN_COUNT-1:0] win_bits;
	logic                 last_sample;
	logic                 pin_valid;

	assign last_sample = (pos_q == LAST_POS);
	assign pin_valid   = (pin_index < 8'(PIN_COUNT));

	// Counts including the current beat, so a closing window sees its last sample.
	always_comb begin
		for (int p = 0; p < PIN_COUNT; p++) begin
			cnt_inc[p]  = cnt_q[p] + CNT_W'(sample_bits[p]);
			win_bits[p] = (CMP_W'(cnt_inc[p]) >= CMP_W'(thr_q));
		end
	end

	always_comb begin
		result            = '0;
		result.ok         = 1'b1;
		result.ready_flag = ready_q;
		case (opcode)
			OP_SAMPLE: begin
				if (last_sample) begin
					result.ready_flag = 1'b1;
				end
			end
			OP_READ: begin
				if (ready_q) begin
					result.levels     = levels_q;
					result.ready_flag = 1'b0;
				end else begin
					result.ok = 1'b0;
				end
			end
			OP_GET_PIN: begin
				if (pin_valid) begin
					result.pin_level = levels_q[pin_index[$clog2(PIN_COUNT)-1:0]];
				end else begin
					result.ok = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			mask_q   <= MASK_RESET;
			pos_q    <= '0;
			levels_q <= '0;
			ready_q  <= 1'b0;
			for (int p = 0; p < PIN_COUNT; p++) begin
				cnt_q[p] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_HIGH_THRESHOLD) begin
					thr_q <= cfg_data[THR_W-1:0];
				end else if (cfg_index == CFG_PIN_ENABLE_MASK) begin
					mask_q <= cfg_data[PIN_COUNT-1:0];
				end
			end
			if (accept) begin
				case (opcode)
					OP_SAMPLE: begin
						if (last_sample) begin
							pos_q    <= '0;
							levels_q <= win_bits & mask_q;
							ready_q  <= 1'b1;
							for (int p = 0; p < PIN_COUNT; p++) begin
								cnt_q[p] <= '0;
							end
						end else begin
							pos_q <= pos_q + CNT_W'(1);
							for (int p = 0; p < PIN_COUNT; p++) begin
								cnt_q[p] <= cnt_inc[p];
							end
						end
					end
					OP_READ: begin
						ready_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

/* rtl/gpio_window_majority_filter.sv */
// Majority filter for eight GPIO pins. Each beat carries an opcode in s_tuser: a sample
// word adds its pin levels to per-pin high counters, and every SAMPLES sample words the
// window closes, pins whose count reaches high_threshold read high, the byte is ANDed
// with pin_enable_mask and held as the filtered levels with the ready flag set. Read
// returns the levels and clears ready (ok low if nothing is ready), get-pin returns one
// level (ok low for pins 8 and up), poll returns the ready flag. Every beat gives exactly
// one result beat. The block takes one beat per cycle while s_tready is high: the counters and
// result logic feed the output register directly, and a skid register behind it lets a new beat
// in while a result is stalled, so s_tready drops only when both hold results. Configuration
// writes are taken in any cycle.
module gpio_window_majority_filter #(
	parameter int SAMPLES = gwmf_pkg::SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gwmf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gwmf_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [gwmf_pkg::IN_DATA_W-1:0]      s_tdata,  // sample_bits[7:0], pin_index[15:8]
	input  logic [1:0]                          s_tuser,  // opcode[1:0]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [gwmf_pkg::OUT_DATA_W-1:0]     m_tdata   // ok, levels[8:1], pin_level, ready_flag, 0
);
	import gwmf_pkg::*;

	logic    accept;
	result_t result;
	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    out_load;

	assign cfg_ready = 1'b1;
	assign s_tready  = !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign out_load  = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {(OUT_DATA_W - RESULT_W)'(0), out_q};

	gwmf_core #(
		.SAMPLES(SAMPLES)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.accept      (accept),
		.opcode      (opcode_t'(s_tuser)),
		.sample_bits (s_tdata[PIN_COUNT-1:0]),
		.pin_index   (s_tdata[15:8]),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= accept;
				end
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= skid_valid_q ? skid_q : result;
		end else if (accept) begin
			skid_q <= result;
		end
	end

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a beat while the output register is empty");

	a_levels_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_q.levels != '0)) |-> (out_q.ok && !out_q.ready_flag))
		else $error("nonzero levels on a beat that is not a successful read");

	a_pin_level_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.pin_level) |-> (out_q.ok && (out_q.levels == '0)))
		else $error("pin level set on a failed or mixed result");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !m_tready) |=> skid_valid_q)
		else $error("stalled skid beat was lost");
`endif

endmodule

/* sim/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gwmf_pkg::*;

	localparam int WINDOW_LEN = SAMPLES_DEF;
	localparam int HOLD_OFF_CYCLES = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = CFG_IDX_W'(2);

	// Tracks the filter state and holds the result beats still owed by the block.
	class majority_tracker;
		logic [THR_W-1:0]     threshold;
		logic [PIN_COUNT-1:0] enable_mask;
		int unsigned          high_count [PIN_COUNT];
		int unsigned          samples_taken;
		logic [PIN_COUNT-1:0] held_levels;
		logic                 levels_ready;
		result_t              owed_results [$];
		int unsigned          fail_count;

		function new();
			threshold     = THR_RESET;
			enable_mask   = MASK_RESET;
			foreach (high_count[p])
				high_count[p] = 0;
			samples_taken = 0;
			held_levels   = '0;
			levels_ready  = 1'b0;
			fail_count    = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_HIGH_THRESHOLD) begin
				threshold = val[THR_W-1:0];
			end else if (idx == CFG_PIN_ENABLE_MASK) begin
				enable_mask = val[PIN_COUNT-1:0];
			end
		endfunction

		function void record_command(opcode_t op, logic [7:0] bits, logic [7:0] pin);
			result_t              r;
			logic [PIN_COUNT-1:0] lv;
			r    = '0;
			r.ok = 1'b1;
			case (op)
				OP_SAMPLE: begin
					for (int p = 0; p < PIN_COUNT; p++)
						if (bits[p])
							high_count[p]++;
					samples_taken++;
					if (samples_taken >= WINDOW_LEN) begin
						lv = '0;
						for (int p = 0; p < PIN_COUNT; p++) begin
							if (high_count[p] >= threshold)
								lv[p] = 1'b1;
							high_count[p] = 0;
						end
						held_levels   = lv & enable_mask;
						levels_ready  = 1'b1;
						samples_taken = 0;
					end
				end
				OP_READ: begin
					if (levels_ready) begin
						r.levels     = held_levels;
						levels_ready = 1'b0;
					end else begin
						r.ok = 1'b0;
					end
				end
				OP_GET_PIN: begin
					if (pin < PIN_COUNT)
						r.pin_level = held_levels[pin[2:0]];
					else
						r.ok = 1'b0;
				end
				default: begin
				end
			endcase
			r.ready_flag = levels_ready;
			owed_results.push_back(r);
		endfunction

		function void compare_result(logic [OUT_DATA_W-1:0] beat);
			result_t got;
			result_t want;
			got = result_t'(beat[RESULT_W-1:0]);
			if (owed_results.size() == 0) begin
				$error("result beat %0h arrived with nothing outstanding", beat);
				fail_count++;
				return;
			end
			want = owed_results.pop_front();
			if (got.ok !== want.ok) begin
				$error("ok: expected %0d, got %0d", want.ok, got.ok);
				fail_count++;
			end
			if (got.levels !== want.levels) begin
				$error("levels: expected %02h, got %02h", want.levels, got.levels);
				fail_count++;
			end
			if (got.pin_level !== want.pin_level) begin
				$error("pin_level: expected %0d, got %0d", want.pin_level, got.pin_level);
				fail_count++;
			end
			if (got.ready_flag !== want.ready_flag) begin
				$error("ready_flag: expected %0d, got %0d", want.ready_flag, got.ready_flag);
				fail_count++;
			end
		endfunction

		function int unsigned outstanding();
			return owed_results.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // sample_bits[7:0], pin_index[15:8]
	logic [1:0]            s_tuser;   // opcode[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // ok, levels[8:1], pin_level, ready_flag, zeros

	majority_tracker tracker;
	int              send_idle_pct;
	int              recv_idle_pct;
	bit              hold_off_req;

	gpio_window_majority_filter #(
		.SAMPLES(WINDOW_LEN)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// The clock starts low so that the first rising edge comes after time zero.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#1ms;
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: random back-pressure, or a long hold-off when asked for.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1)
					@(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.compare_result(m_tdata);
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		tracker.write_register(idx, val);
	endtask

	task automatic configure(input logic [THR_W-1:0] thr, input logic [PIN_COUNT-1:0] mask);
		write_reg(CFG_HIGH_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(CFG_PIN_ENABLE_MASK, mask);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_cmd(input opcode_t op, input logic [7:0] bits, input logic [7:0] pin);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {pin, bits};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.record_command(op, bits, pin);
	endtask

	// Stop offering beats and let every owed result come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
		repeat (3)
			@(posedge clk);
	endtask

	task automatic pick_cmd(output opcode_t op, output logic [7:0] bits, output logic [7:0] pin);
		int r;
		r = $urandom_range(99);
		if (r < 60)
			op = OP_SAMPLE;
		else if (r < 75)
			op = OP_READ;
		else if (r < 90)
			op = OP_GET_PIN;
		else
			op = OP_POLL;
		r = $urandom_range(99);
		if (r < 10)
			bits = 8'hFF;
		else if (r < 20)
			bits = 8'h00;
		else
			bits = 8'($urandom_range(255));
		if ($urandom_range(99) < 75)
			pin = 8'($urandom_range(PIN_COUNT - 1));
		else
			pin = 8'($urandom_range(255));
	endtask

	initial begin
		opcode_t              op;
		logic [7:0]           bits;
		logic [7:0]           pin;
		logic [THR_W-1:0]     phase_thr [6];
		logic [PIN_COUNT-1:0] phase_mask [6];

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = '0;
		send_idle_pct = 37;
		recv_idle_pct = 76;
		hold_off_req  = 1'b0;
		tracker       = new();

		phase_thr  = '{4'd3, 4'd0, 4'd8, 4'd15, 4'd1, 4'd5};
		phase_mask = '{8'hFF, 8'h5A, 8'h00, 8'hFF, 8'($urandom_range(255)), 8'hA5};

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(THR_RESET, MASK_RESET);

		// Nothing stored yet: poll, failed read, get-level of the reset levels, bad pins.
		send_cmd(OP_POLL, 8'h00, 8'h00);
		send_cmd(OP_READ, 8'hFF, 8'hFF);
		send_cmd(OP_GET_PIN, 8'h00, 8'd0);
		send_cmd(OP_GET_PIN, 8'h00, 8'd8);
		send_cmd(OP_GET_PIN, 8'hFF, 8'd255);
		// Pin p is high in 8-p samples of this window, so the counts span 1 to 8.
		for (int k = 0; k < WINDOW_LEN; k++)
			send_cmd(OP_SAMPLE, 8'hFF >> k, 8'($urandom_range(255)));
		send_cmd(OP_POLL, 8'hFF, 8'hFF);
		send_cmd(OP_GET_PIN, 8'h00, 8'd7);
		send_cmd(OP_GET_PIN, 8'h00, 8'd3);
		send_cmd(OP_READ, 8'h00, 8'h00);
		send_cmd(OP_READ, 8'h00, 8'h00);
		send_cmd(OP_GET_PIN, 8'h00, 8'd0);
		drain_results();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 37;
				recv_idle_pct = 76;
			end else if (ph < 4) begin
				send_idle_pct = 76;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (ph == 2)
				write_reg(CFG_UNUSED_INDEX, 8'($urandom_range(255)));
			configure(phase_thr[ph], phase_mask[ph]);
			for (int i = 0; i < 165; i++) begin
				if (ph == 4 && i == 20)
					hold_off_req = 1'b1;
				if (i == 100)
					drain_results();
				pick_cmd(op, bits, pin);
				send_cmd(op, bits, pin);
			end
			drain_results();
		end

		if (tracker.fail_count == 0 && tracker.outstanding() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
